/* sv/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types, codes and constants for the console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // Tab stop spacing and the width of the column phase counter.
   localparam int TAB_STOP = 8;
   localparam int PHASE_W  = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;

   // Register reset values.
   localparam logic [7:0] COLUMNS_RESET  = 8'd80;
   localparam logic [5:0] LAST_ROW_RESET = 6'd24;

   // Character codes with a special meaning.
   localparam logic [7:0]  NEWLINE = 8'h0a;
   localparam logic [15:0] BLANK   = 16'h0020;

   // Configuration address width: two word registers.
   localparam int CSR_ADDR_W = 3;

   // Result operation codes.
   typedef enum logic [1:0] {
      OP_SINGLE = 2'd0,
      OP_DOUBLE = 2'd1,
      OP_SCROLL = 2'd2,
      OP_CURSOR = 2'd3
   } op_type;

   // Register indexes.
   typedef enum logic {
      REG_COLUMNS  = 1'b0,
      REG_LAST_ROW = 1'b1
   } reg_index_type;

   // What the output register is loaded with.
   typedef enum logic [1:0] {
      SEL_BLANK  = 2'd0,
      SEL_CELL   = 2'd1,
      SEL_SCROLL = 2'd2,
      SEL_CURSOR = 2'd3
   } emit_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_item;
      logic         emit;
      emit_sel_type sel;
      logic         last;
      logic         set_lead;
      logic         nl_move;
      logic         cell_move;
      logic         tab_move;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tab;
      logic has_lead;
      logic top_bit;
      logic is_newline;
      logic tab_more;
      logic tab_next_more;
      logic nl_scroll;
      logic wrap_scroll;
      logic out_free;
   } dp_status_type;

endpackage

/* sv/tcce_csr.sv */
// ----------------------------------------------------------------------------
// Console cursor engine registers
// Bus-style register port holding the column count and the bottom row index.
// ----------------------------------------------------------------------------
module tcce_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [7:0]                      columns,
   output logic [5:0]                      last_row
);

   logic [7:0]              columns_ff, columns_in;
   logic [5:0]              last_row_ff, last_row_in;
   logic                    write_en;
   tcce_pkg::reg_index_type index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign index      = tcce_pkg::reg_index_type'(csr_paddr[2]);

   // Register write decode.
   always_comb begin
      columns_in  = columns_ff;
      last_row_in = last_row_ff;
      if (write_en) begin
         unique case (index)
            tcce_pkg::REG_COLUMNS:  columns_in  = csr_pwdata[7:0];
            tcce_pkg::REG_LAST_ROW: last_row_in = csr_pwdata[5:0];
            default:                columns_in  = columns_ff;
         endcase
      end
   end

   // Read decode.
   always_comb begin
      unique case (index)
         tcce_pkg::REG_COLUMNS:  csr_prdata = {24'd0, columns_ff};
         tcce_pkg::REG_LAST_ROW: csr_prdata = {26'd0, last_row_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= tcce_pkg::COLUMNS_RESET;
         last_row_ff <= tcce_pkg::LAST_ROW_RESET;
      end else begin
         columns_ff  <= columns_in;
         last_row_ff <= last_row_in;
      end
   end

   assign columns  = columns_ff;
   assign last_row = last_row_ff;

endmodule

/* sv/tcce_ctrl.sv */
// ----------------------------------------------------------------------------
// Console cursor engine controller
// Sequences one item at a time and issues one result per step.
// ----------------------------------------------------------------------------
module tcce_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  tcce_pkg::dp_status_type status,
   output tcce_pkg::dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_TAB    = 6'b000100,
      ST_CELL   = 6'b001000,
      ST_SCROLL = 6'b010000,
      ST_CURSOR = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = tcce_pkg::SEL_BLANK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_tab) begin
               state_in = status.tab_more ? ST_TAB : ST_IDLE;
            end else if (status.has_lead) begin
               state_in = ST_CELL;
            end else if (status.top_bit) begin
               cmd.set_lead = 1'b1;
               state_in     = ST_IDLE;
            end else if (status.is_newline) begin
               cmd.nl_move = 1'b1;
               state_in    = status.nl_scroll ? ST_SCROLL : ST_CURSOR;
            end else begin
               state_in = ST_CELL;
            end
         end
         ST_TAB: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = tcce_pkg::SEL_BLANK;
               cmd.last     = !status.tab_next_more;
               cmd.tab_move = 1'b1;
               if (!status.tab_next_more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CELL: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = tcce_pkg::SEL_CELL;
               cmd.cell_move = 1'b1;
               state_in      = status.wrap_scroll ? ST_SCROLL : ST_CURSOR;
            end
         end
         ST_SCROLL: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = tcce_pkg::SEL_SCROLL;
               state_in = ST_CURSOR;
            end
         end
         ST_CURSOR: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = tcce_pkg::SEL_CURSOR;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/tcce_dpath.sv */
// ----------------------------------------------------------------------------
// Console cursor engine datapath
// Cursor, lead byte and tab phase registers, plus the result output register.
// ----------------------------------------------------------------------------
module tcce_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tuser,
   input  logic [7:0]              req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  logic [7:0]              columns,
   input  logic [5:0]              last_row,
   input  tcce_pkg::dp_cmd_type    cmd,
   output tcce_pkg::dp_status_type status
);

   localparam int PW = tcce_pkg::PHASE_W;
   localparam logic [PW-1:0] TAB_LAST = PW'(tcce_pkg::TAB_STOP - 1);
   localparam logic [PW:0]   TAB_WRAP = (PW + 1)'(tcce_pkg::TAB_STOP);

   // Cursor state and the latched item.
   logic [7:0]    x_ff, x_in;
   logic [5:0]    y_ff, y_in;
   logic [7:0]    lead_ff, lead_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic          kind_ff, kind_in;
   logic [7:0]    byte_ff, byte_in;

   // Output register.
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_op_ff, out_op_in;
   logic [7:0]    out_col_ff, out_col_in;
   logic [5:0]    out_row_ff, out_row_in;
   logic [15:0]   out_code_ff, out_code_in;
   logic          out_last_ff, out_last_in;

   logic          has_lead;
   logic [8:0]    x_adv;
   logic [8:0]    x_inc;
   logic [6:0]    y_inc;
   logic          wrap;
   logic [PW:0]   phase_sum;
   logic [PW-1:0] phase_adv;
   logic [PW-1:0] phase_inc;

   // Cursor arithmetic: a double cell advances two columns, a single one.
   always_comb begin
      has_lead  = (lead_ff != 8'd0);
      x_adv     = {1'b0, x_ff} + (has_lead ? 9'd2 : 9'd1);
      x_inc     = {1'b0, x_ff} + 9'd1;
      y_inc     = {1'b0, y_ff} + 7'd1;
      wrap      = (x_adv >= {1'b0, columns});
      phase_sum = {1'b0, phase_ff} + (has_lead ? (PW + 1)'(2) : (PW + 1)'(1));
      if (phase_sum >= TAB_WRAP) begin
         phase_adv = PW'(phase_sum - TAB_WRAP);
      end else begin
         phase_adv = phase_sum[PW-1:0];
      end
      phase_inc = phase_ff + PW'(1);
   end

   // Status toward the controller.
   always_comb begin
      status.is_tab        = kind_ff;
      status.has_lead      = has_lead;
      status.top_bit       = byte_ff[7];
      status.is_newline    = (byte_ff == tcce_pkg::NEWLINE);
      status.tab_more      = (x_ff < columns) && (phase_ff != TAB_LAST);
      status.tab_next_more = (x_inc < {1'b0, columns}) && (phase_inc != TAB_LAST);
      status.nl_scroll     = (y_ff >= last_row);
      status.wrap_scroll   = wrap && (y_inc > {1'b0, last_row});
      status.out_free      = !out_valid_ff || rsp_tready;
   end

   // Cursor, lead and item register updates.
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      lead_in  = lead_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      if (cmd.load_item) begin
         kind_in = req_tuser;
         byte_in = req_tdata;
      end
      if (cmd.set_lead) begin
         lead_in = byte_ff;
      end
      if (cmd.tab_move) begin
         x_in     = x_inc[7:0];
         phase_in = phase_inc;
      end
      if (cmd.nl_move) begin
         x_in     = 8'd0;
         phase_in = '0;
         if (!status.nl_scroll) begin
            y_in = y_inc[5:0];
         end
      end
      if (cmd.cell_move) begin
         lead_in = 8'd0;
         if (wrap) begin
            x_in     = 8'd0;
            phase_in = '0;
            y_in     = status.wrap_scroll ? last_row : y_inc[5:0];
         end else begin
            x_in     = x_adv[7:0];
            phase_in = phase_adv;
         end
      end
   end

   // Output register load; the fields come from the state before the update.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_op_in    = out_op_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_last_in  = cmd.last;
         unique case (cmd.sel)
            tcce_pkg::SEL_BLANK: begin
               out_op_in   = tcce_pkg::OP_SINGLE;
               out_col_in  = x_ff;
               out_row_in  = y_ff;
               out_code_in = tcce_pkg::BLANK;
            end
            tcce_pkg::SEL_CELL: begin
               out_op_in   = has_lead ? tcce_pkg::OP_DOUBLE : tcce_pkg::OP_SINGLE;
               out_col_in  = x_ff;
               out_row_in  = y_ff;
               out_code_in = has_lead ? {lead_ff, byte_ff} : {8'd0, byte_ff};
            end
            tcce_pkg::SEL_SCROLL: begin
               out_op_in   = tcce_pkg::OP_SCROLL;
               out_col_in  = 8'd0;
               out_row_in  = 6'd0;
               out_code_in = 16'd0;
            end
            tcce_pkg::SEL_CURSOR: begin
               out_op_in   = tcce_pkg::OP_CURSOR;
               out_col_in  = x_ff;
               out_row_in  = y_ff;
               out_code_in = 16'd0;
            end
            default: begin
               out_op_in = tcce_pkg::OP_SINGLE;
            end
         endcase
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= 8'd0;
         y_ff         <= 6'd0;
         lead_ff      <= 8'd0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         x_ff         <= x_in;
         y_ff         <= y_in;
         lead_ff      <= lead_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      out_op_ff   <= out_op_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_op_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_code_ff, out_row_ff, out_col_ff};

endmodule

/* sv/text_console_cursor_engine_top.sv */
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns console bytes and tab requests into cell writes, scrolls and cursor
// updates while tracking the cursor position and a pending double-byte lead.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Content
//   req_*     in         tvalid/tready      tuser: kind; tdata: char_byte
//   rsp_*     out        tvalid/tready      tuser: op; tdata: col,row,code;
//                                           tlast: last
//   csr_*     in         psel/penable       columns (0x0), last_row (0x4)
//
// One item is worked at a time: it is taken while idle, then decoded, and each
// result is issued from a state of its own. A printed cell gives a cell write
// and a cursor update (a scroll between when it scrolls), a lead byte or an
// empty tab nothing, and a tab one blank per column (up to TAB_STOP - 1).
// Reset is synchronous and puts the cursor at the top left with no lead.
// A result waits in the output register while rsp_tready is low; the
// controller holds until it is taken, and a new item is accepted while the
// final result of the previous one still waits.
//
module text_console_cursor_engine_top (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_byte
   input  logic                            req_tuser,   // [0] kind
   // Result items.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [7:0] col, [13:8] row,
                                                        // [29:14] code, [31:30] zero
   output logic [1:0]                      rsp_tuser,   // [1:0] op
   output logic                            rsp_tlast,
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [7:0]              columns;
   logic [5:0]              last_row;
   tcce_pkg::dp_cmd_type    cmd;
   tcce_pkg::dp_status_type status;

   tcce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .columns     (columns),
      .last_row    (last_row)
   );

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcce_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .columns    (columns),
      .last_row   (last_row),
      .cmd        (cmd),
      .status     (status)
   );

   // A result is only loaded when the output register is free or being drained.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending result");

   // Nothing is emitted while the engine waits for an item.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.emit)
      else $error("result emitted while idle");

   // A cursor update always closes the results of its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tcce_pkg::OP_CURSOR) |-> rsp_tlast)
      else $error("cursor update without last");

   // A scroll is always followed by a cursor update.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tcce_pkg::OP_SCROLL) |-> !rsp_tlast)
      else $error("scroll marked as last");

endmodule
